// File: design/rotation_matrix_to_quaternion_core_assert.svh
// Assertion macros used by the checker of the matrix to quaternion core.
`ifndef ROTATION_MATRIX_TO_QUATERNION_CORE_ASSERT_SVH
`define ROTATION_MATRIX_TO_QUATERNION_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RMQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RMQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/rmq_pkg.sv
// Types, widths and helpers shared by the matrix to quaternion core.
package rmq_pkg;

	localparam int DATA_WIDTH = 16;
	localparam int FRAC_BITS  = 14;

	// radicand, signed
	localparam int RAD_W = DATA_WIDTH + 3;
	// sum or difference of two entries, signed
	localparam int D_W   = DATA_WIDTH + 1;
	// square root result width and its operand width
	localparam int RTW   = (DATA_WIDTH + FRAC_BITS + 3) / 2;
	localparam int SQ_W  = 2 * RTW;
	// dividend magnitude, and divisor (twice the root)
	localparam int NUM_W = D_W + FRAC_BITS;
	localparam int DIV_W = RTW + 1;

	typedef logic signed [DATA_WIDTH-1:0] fix_t;

	typedef struct packed {
		fix_t m00;
		fix_t m01;
		fix_t m02;
		fix_t m10;
		fix_t m11;
		fix_t m12;
		fix_t m20;
		fix_t m21;
		fix_t m22;
	} mat_t;

	typedef struct packed {
		fix_t qw;
		fix_t qx;
		fix_t qy;
		fix_t qz;
		logic invalid;
	} quat_t;

	// component that comes from the square root
	typedef enum logic [1:0] {
		COMP_W,
		COMP_X,
		COMP_Y,
		COMP_Z
	} comp_t;

	typedef struct packed {
		logic signed [RAD_W-1:0] rad;
		comp_t                   sel;
		logic [3:0][D_W-1:0]     d;
	} front_item_t;

	localparam logic signed [NUM_W:0] SAT_HI = (NUM_W+1)'(2**(DATA_WIDTH-1) - 1);
	localparam logic signed [NUM_W:0] SAT_LO = -SAT_HI - (NUM_W+1)'(1);

	function automatic fix_t sat_fix(input logic signed [NUM_W:0] v);
		fix_t r;
		if (v > SAT_HI) r = SAT_HI[DATA_WIDTH-1:0];
		else if (v < SAT_LO) r = SAT_LO[DATA_WIDTH-1:0];
		else r = v[DATA_WIDTH-1:0];
		return r;
	endfunction

endpackage

// File: design/rmq_front.sv
// Front stage: trace test, diagonal selection, radicand and the four numerators.
module rmq_front import rmq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  mat_t        in_data,
	output logic        push,
	output front_item_t item,
	input  logic        full
);

	localparam logic signed [RAD_W-1:0] ONE_R = RAD_W'(2**FRAC_BITS);

	logic signed [RAD_W-1:0] e00, e11, e22, trace;
	logic signed [D_W-1:0]   x01, x02, x10, x12, x20, x21;
	logic                    trace_pos, pick1, pick2;
	comp_t                   sel_c;
	front_item_t             nxt;
	front_item_t             item_s1;
	logic                    v_s1;

	assign e00 = RAD_W'(in_data.m00);
	assign e11 = RAD_W'(in_data.m11);
	assign e22 = RAD_W'(in_data.m22);
	assign x01 = D_W'(in_data.m01);
	assign x02 = D_W'(in_data.m02);
	assign x10 = D_W'(in_data.m10);
	assign x12 = D_W'(in_data.m12);
	assign x20 = D_W'(in_data.m20);
	assign x21 = D_W'(in_data.m21);

	assign trace     = e00 + e11 + e22;
	assign trace_pos = trace > 0;
	assign pick1     = in_data.m11 > in_data.m00;
	assign pick2     = pick1 ? (in_data.m22 > in_data.m11) : (in_data.m22 > in_data.m00);

	always_comb begin
		if (trace_pos) sel_c = COMP_W;
		else if (pick2) sel_c = COMP_Z;
		else if (pick1) sel_c = COMP_Y;
		else sel_c = COMP_X;
	end

	always_comb begin
		nxt.sel = sel_c;
		unique case (sel_c)
			COMP_W: begin
				nxt.rad  = trace + ONE_R;
				nxt.d[0] = '0;
				nxt.d[1] = x21 - x12;
				nxt.d[2] = x02 - x20;
				nxt.d[3] = x10 - x01;
			end
			COMP_X: begin
				nxt.rad  = e00 - e11 - e22 + ONE_R;
				nxt.d[0] = x21 - x12;
				nxt.d[1] = '0;
				nxt.d[2] = x10 + x01;
				nxt.d[3] = x20 + x02;
			end
			COMP_Y: begin
				nxt.rad  = e11 - e22 - e00 + ONE_R;
				nxt.d[0] = x02 - x20;
				nxt.d[1] = x01 + x10;
				nxt.d[2] = '0;
				nxt.d[3] = x21 + x12;
			end
			COMP_Z: begin
				nxt.rad  = e22 - e00 - e11 + ONE_R;
				nxt.d[0] = x10 - x01;
				nxt.d[1] = x02 + x20;
				nxt.d[2] = x12 + x21;
				nxt.d[3] = '0;
			end
			default: begin
				nxt.rad = '0;
				nxt.d   = '0;
			end
		endcase
	end

	assign in_ready = !v_s1 || !full;
	assign push     = v_s1 && !full;
	assign item     = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= nxt;
		end
	end

endmodule

// File: design/rmq_fifo.sv
// Short queue between front and back, with a registered head entry.
module rmq_fifo import rmq_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  front_item_t wdata,
	output logic        full,
	input  logic        pop,
	output front_item_t rdata,
	output logic        empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	front_item_t     mem [DEPTH];
	logic [AW-1:0]   wp_q, rp_q;
	logic [CW-1:0]   cnt_q;
	logic            head_v_q;
	front_item_t     head_q;
	logic            wr, ld;

	assign full  = cnt_q == CW'(DEPTH);
	assign wr    = push && !full;
	assign ld    = (cnt_q != '0) && (!head_v_q || pop);
	assign empty = !head_v_q;
	assign rdata = head_q;

	function automatic logic [AW-1:0] nxt_ptr(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q     <= '0;
			rp_q     <= '0;
			cnt_q    <= '0;
			head_v_q <= 1'b0;
		end else begin
			if (wr) wp_q <= nxt_ptr(wp_q);
			if (ld) rp_q <= nxt_ptr(rp_q);
			if (wr && !ld) cnt_q <= cnt_q + CW'(1);
			else if (!wr && ld) cnt_q <= cnt_q - CW'(1);
			if (ld) head_v_q <= 1'b1;
			else if (pop) head_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem[wp_q] <= wdata;
		if (ld) head_q <= mem[rp_q];
	end

endmodule

// File: design/rmq_back.sv
// Back end: pipelined square root, four pipelined dividers, saturation and output register.
module rmq_back import rmq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        empty,
	input  front_item_t item,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output quat_t       out_data
);

	localparam int NS = RTW;
	localparam int ND = NUM_W;

	logic en;

	// square root stages
	logic             sq_v    [NS+1];
	logic             sq_inv  [NS+1];
	comp_t            sq_sel  [NS+1];
	logic [SQ_W-1:0]  sq_n    [NS+1];
	logic [RTW:0]     sq_rem  [NS+1];
	logic [RTW-1:0]   sq_root [NS+1];
	logic [3:0]       sq_sgn  [NS+1];
	logic [NUM_W-1:0] sq_mag  [NS+1][4];
	logic [RTW:0]     sq_rem_nx  [NS];
	logic [RTW-1:0]   sq_root_nx [NS];

	// divider stages
	logic             dv_v    [ND+1];
	logic             dv_inv  [ND+1];
	comp_t            dv_sel  [ND+1];
	logic [RTW-1:0]   dv_root [ND+1];
	logic [3:0]       dv_sgn  [ND+1];
	logic [DIV_W-1:0] dv_rem  [ND+1][4];
	logic [NUM_W-1:0] dv_num  [ND+1][4];
	logic [DIV_W-1:0] dv_rem_nx [ND][4];
	logic [NUM_W-1:0] dv_num_nx [ND][4];

	// entry values
	logic                    inv0;
	logic [SQ_W-1:0]         n0;
	logic [3:0]              sgn0;
	logic [NUM_W-1:0]        mag0 [4];
	logic signed [D_W:0]     dext [4];
	logic signed [D_W:0]     dabs [4];

	logic                    out_v_q;
	quat_t                   out_q;
	fix_t                    comp_val [4];
	logic signed [NUM_W:0]   qs [4];
	logic signed [NUM_W:0]   half_root;
	quat_t                   res;

	assign en        = !out_v_q || out_ready;
	assign pop       = !empty && en;
	assign out_valid = out_v_q;
	assign out_data  = out_q;

	assign inv0 = item.rad[RAD_W-1] || (item.rad == '0);
	assign n0   = SQ_W'({item.rad[DATA_WIDTH+1:0], {FRAC_BITS{1'b0}}});

	always_comb begin
		for (int l = 0; l < 4; l++) begin
			dext[l]    = (D_W+1)'(signed'(item.d[l]));
			sgn0[l]    = item.d[l][D_W-1];
			dabs[l]    = sgn0[l] ? -dext[l] : dext[l];
			mag0[l]    = {dabs[l][D_W-1:0], {FRAC_BITS{1'b0}}};
		end
	end

	// one result bit per square root stage
	always_comb begin
		logic [RTW+2:0] rem_t, cand, diff;
		for (int s = 0; s < NS; s++) begin
			rem_t = {sq_rem[s], sq_n[s][SQ_W-1 -: 2]};
			cand  = {1'b0, sq_root[s], 2'b01};
			diff  = rem_t - cand;
			if (rem_t >= cand) begin
				sq_rem_nx[s]  = diff[RTW:0];
				sq_root_nx[s] = {sq_root[s][RTW-2:0], 1'b1};
			end else begin
				sq_rem_nx[s]  = rem_t[RTW:0];
				sq_root_nx[s] = {sq_root[s][RTW-2:0], 1'b0};
			end
		end
	end

	// one quotient bit per divider stage and lane
	always_comb begin
		logic [DIV_W:0]   r_t, dvs, diff;
		for (int s = 0; s < ND; s++) begin
			for (int l = 0; l < 4; l++) begin
				r_t  = {dv_rem[s][l], dv_num[s][l][NUM_W-1]};
				dvs  = {1'b0, dv_root[s], 1'b0};
				diff = r_t - dvs;
				if (r_t >= dvs) begin
					dv_rem_nx[s][l] = diff[DIV_W-1:0];
					dv_num_nx[s][l] = {dv_num[s][l][NUM_W-2:0], 1'b1};
				end else begin
					dv_rem_nx[s][l] = r_t[DIV_W-1:0];
					dv_num_nx[s][l] = {dv_num[s][l][NUM_W-2:0], 1'b0};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s <= NS; s++) sq_v[s] <= 1'b0;
			for (int s = 0; s <= ND; s++) dv_v[s] <= 1'b0;
			out_v_q <= 1'b0;
		end else if (en) begin
			sq_v[0] <= pop;
			for (int s = 0; s < NS; s++) sq_v[s+1] <= sq_v[s];
			dv_v[0] <= sq_v[NS];
			for (int s = 0; s < ND; s++) dv_v[s+1] <= dv_v[s];
			out_v_q <= dv_v[ND];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_inv[0]  <= inv0;
			sq_sel[0]  <= item.sel;
			sq_n[0]    <= n0;
			sq_rem[0]  <= '0;
			sq_root[0] <= '0;
			sq_sgn[0]  <= sgn0;
			for (int l = 0; l < 4; l++) sq_mag[0][l] <= mag0[l];
			for (int s = 0; s < NS; s++) begin
				sq_inv[s+1]  <= sq_inv[s];
				sq_sel[s+1]  <= sq_sel[s];
				sq_n[s+1]    <= {sq_n[s][SQ_W-3:0], 2'b00};
				sq_rem[s+1]  <= sq_rem_nx[s];
				sq_root[s+1] <= sq_root_nx[s];
				sq_sgn[s+1]  <= sq_sgn[s];
				for (int l = 0; l < 4; l++) sq_mag[s+1][l] <= sq_mag[s][l];
			end

			dv_inv[0]  <= sq_inv[NS];
			dv_sel[0]  <= sq_sel[NS];
			dv_root[0] <= sq_root[NS];
			dv_sgn[0]  <= sq_sgn[NS];
			for (int l = 0; l < 4; l++) begin
				dv_rem[0][l] <= '0;
				dv_num[0][l] <= sq_mag[NS][l];
			end
			for (int s = 0; s < ND; s++) begin
				dv_inv[s+1]  <= dv_inv[s];
				dv_sel[s+1]  <= dv_sel[s];
				dv_root[s+1] <= dv_root[s];
				dv_sgn[s+1]  <= dv_sgn[s];
				for (int l = 0; l < 4; l++) begin
					dv_rem[s+1][l] <= dv_rem_nx[s][l];
					dv_num[s+1][l] <= dv_num_nx[s][l];
				end
			end

			out_q <= res;
		end
	end

	// apply sign, saturate, drop in the root half, zero everything when invalid
	assign half_root = (NUM_W+1)'(dv_root[ND] >> 1);

	always_comb begin
		for (int l = 0; l < 4; l++) begin
			qs[l] = dv_sgn[ND][l] ? -signed'({1'b0, dv_num[ND][l]})
			                      :  signed'({1'b0, dv_num[ND][l]});
			if (dv_inv[ND]) comp_val[l] = '0;
			else if (dv_sel[ND] == comp_t'(l)) comp_val[l] = sat_fix(half_root);
			else comp_val[l] = sat_fix(qs[l]);
		end
		res.qw      = comp_val[0];
		res.qx      = comp_val[1];
		res.qy      = comp_val[2];
		res.qz      = comp_val[3];
		res.invalid = dv_inv[ND];
	end

endmodule

// File: design/rotation_matrix_to_quaternion_core.sv
// Top level of the rotation matrix to unit quaternion core.
//
//  channel  | handshake            | payload
//  ---------+----------------------+----------------------------------------
//  input    | in_valid / in_ready  | in_data  : mat_t (m00..m22, Q2.14)
//  output   | out_valid / out_ready| out_data : quat_t (qw..qz, invalid)
//
// One matrix per cycle is accepted while the queue has room; out_valid rises once it has
// passed the front register, queue head, root and divider stages and the output register.
// Reset clears all valid bits and the queue pointers; payload registers are not reset.
// A stall at the output freezes the back pipeline; the queue then fills and the
// front stops taking items only once the queue is full.
module rotation_matrix_to_quaternion_core import rmq_pkg::*; #(
	parameter int FIFO_DEPTH = 4
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  mat_t  in_data,
	output logic  out_valid,
	input  logic  out_ready,
	output quat_t out_data
);

	logic        push, full, pop, empty;
	front_item_t f_item, b_item;

	rmq_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.push     (push),
		.item     (f_item),
		.full     (full)
	);

	rmq_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (f_item),
		.full   (full),
		.pop    (pop),
		.rdata  (b_item),
		.empty  (empty)
	);

	rmq_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (empty),
		.item      (b_item),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// File: design/rmq_checker.sv
// Port-level checker for the matrix to quaternion core, bound to the top level.
`include "rotation_matrix_to_quaternion_core_assert.svh"

module rmq_checker import rmq_pkg::*; (
	input logic  clk,
	input logic  arst_n,
	input logic  in_valid,
	input logic  in_ready,
	input mat_t  in_data,
	input logic  out_valid,
	input logic  out_ready,
	input quat_t out_data
);

	logic any_nz;
	logic inv_out, ok_out, out_stall, in_stall;
	assign any_nz = (out_data.qw != '0) || (out_data.qx != '0) ||
	                (out_data.qy != '0) || (out_data.qz != '0);
	assign inv_out   = out_valid && out_data.invalid;
	assign ok_out    = out_valid && !out_data.invalid;
	assign out_stall = out_valid && !out_ready;
	assign in_stall  = in_valid && !in_ready;

	`RMQ_ASSERT_IMP(a_inv_zero, clk, arst_n, inv_out, !any_nz, "invalid result not zero")
	`RMQ_ASSERT_IMP(a_ok_nonzero, clk, arst_n, ok_out, any_nz, "valid result is all zero")
	`RMQ_ASSERT_NXT(a_out_hold, clk, arst_n, out_stall, out_valid, "output transaction dropped")
	`RMQ_ASSERT_NXT(a_out_stable, clk, arst_n, out_stall, $stable(out_data), "stalled output changed")
	`RMQ_ASSERT_NXT(a_in_hold, clk, arst_n, in_stall, in_valid && $stable(in_data), "input moved")

endmodule

bind rotation_matrix_to_quaternion_core rmq_checker u_rmq_checker (.*);

// File: dv/rotation_matrix_to_quaternion_core_tb.sv
// Self-checking testbench for the rotation matrix to quaternion core.
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion_core_tb;
	import rmq_pkg::*;

	localparam int LATENCY = 60;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int N_RANDOM = 1500;

	logic  clk;
	logic  arst_n;
	logic  in_valid;
	logic  in_ready;
	mat_t  in_data;
	logic  out_valid;
	logic  out_ready;
	quat_t out_data;

	mat_t  pending_mats[$];
	quat_t expected_quats[$];
	bit    stimulus_done;
	bit    hold_sender;
	bit    in_fire_q;
	bit    out_fire_q;
	int    error_count;
	int    idle_cycles;
	int    send_gap;
	int    recv_gap;

	rotation_matrix_to_quaternion_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned res;
		longint unsigned bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic fix_t clamp16(longint v);
		if (v > 32767) return 16'sh7fff;
		if (v < -32768) return 16'sh8000;
		return fix_t'(v);
	endfunction

	function automatic longint div_by_root(longint d, longint root);
		return (d * (longint'(1) << FRAC_BITS)) / (2 * root);
	endfunction

	function automatic quat_t matrix_to_quat(mat_t mt);
		longint m[3][3];
		longint q[4];
		longint one, rad, tr, root;
		int i, j, k;
		quat_t r;
		m[0][0] = mt.m00; m[0][1] = mt.m01; m[0][2] = mt.m02;
		m[1][0] = mt.m10; m[1][1] = mt.m11; m[1][2] = mt.m12;
		m[2][0] = mt.m20; m[2][1] = mt.m21; m[2][2] = mt.m22;
		one = longint'(1) << FRAC_BITS;
		q = '{0, 0, 0, 0};
		tr = m[0][0] + m[1][1] + m[2][2];
		i = -1; j = 0; k = 0;
		if (tr > 0) begin
			rad = tr + one;
		end else begin
			i = 0;
			if (m[1][1] > m[0][0]) i = 1;
			if (m[2][2] > m[i][i]) i = 2;
			j = (i + 1) % 3;
			k = (j + 1) % 3;
			rad = m[i][i] - m[j][j] - m[k][k] + one;
		end
		root = 0;
		if (rad > 0) root = longint'(int_sqrt(longint'(rad) << FRAC_BITS));
		r = '0;
		if (root <= 0) begin
			r.invalid = 1'b1;
			return r;
		end
		if (i < 0) begin
			q[0] = root >>> 1;
			q[1] = div_by_root(m[2][1] - m[1][2], root);
			q[2] = div_by_root(m[0][2] - m[2][0], root);
			q[3] = div_by_root(m[1][0] - m[0][1], root);
		end else begin
			q[1 + i] = root >>> 1;
			q[0] = div_by_root(m[k][j] - m[j][k], root);
			q[1 + j] = div_by_root(m[j][i] + m[i][j], root);
			q[1 + k] = div_by_root(m[k][i] + m[i][k], root);
		end
		r.qw = clamp16(q[0]);
		r.qx = clamp16(q[1]);
		r.qy = clamp16(q[2]);
		r.qz = clamp16(q[3]);
		return r;
	endfunction

	function automatic mat_t diag_mat(int a, int b, int c);
		mat_t mt;
		mt = '0;
		mt.m00 = fix_t'(a);
		mt.m11 = fix_t'(b);
		mt.m22 = fix_t'(c);
		return mt;
	endfunction

	// matrix with a perturbed signed diagonal and random off-diagonal entries
	function automatic mat_t rotation_like();
		mat_t mt;
		int s;
		mt = '0;
		s = $urandom_range(0, 3);
		mt.m00 = fix_t'(((s == 1 || s == 2) ? -16384 : 16384) + $urandom_range(0, 4000) - 2000);
		mt.m11 = fix_t'(((s == 1 || s == 3) ? -16384 : 16384) + $urandom_range(0, 4000) - 2000);
		mt.m22 = fix_t'(((s == 2 || s == 3) ? -16384 : 16384) + $urandom_range(0, 4000) - 2000);
		mt.m01 = fix_t'($urandom_range(0, 32768) - 16384);
		mt.m02 = fix_t'($urandom_range(0, 32768) - 16384);
		mt.m10 = fix_t'($urandom_range(0, 32768) - 16384);
		mt.m12 = fix_t'($urandom_range(0, 32768) - 16384);
		mt.m20 = fix_t'($urandom_range(0, 32768) - 16384);
		mt.m21 = fix_t'($urandom_range(0, 32768) - 16384);
		return mt;
	endfunction

	initial begin
		mat_t mt;
		// positive trace, zero trace, each diagonal winner, ties
		pending_mats.push_back(diag_mat(16384, 16384, 16384));
		pending_mats.push_back(diag_mat(0, 0, 0));
		pending_mats.push_back(diag_mat(16384, -16384, -16384));
		pending_mats.push_back(diag_mat(-16384, 16384, -16384));
		pending_mats.push_back(diag_mat(-16384, -16384, 16384));
		pending_mats.push_back(diag_mat(-8192, -8192, -8192));
		pending_mats.push_back(diag_mat(-4000, 2000, 2000));
		pending_mats.push_back(diag_mat(1, 0, -1));
		// extreme diagonal entries, large radicands
		pending_mats.push_back(diag_mat(-32768, -32768, -32768));
		pending_mats.push_back(diag_mat(0, 32767, 32767) );
		pending_mats.push_back(diag_mat(-32768, 16384, 16383));
		pending_mats.push_back(diag_mat(-16000, 32767, 32767));
		// extremes of off-diagonals, saturation
		mt = {9{16'sh7fff}};
		pending_mats.push_back(mt);
		mt = {9{16'sh8000}};
		pending_mats.push_back(mt);
		mt = diag_mat(-32768, -32768, -32767);
		mt.m01 = 16'sh7fff; mt.m10 = 16'sh8000; mt.m21 = 16'sh7fff; mt.m12 = 16'sh8000;
		mt.m02 = 16'sh8000; mt.m20 = 16'sh7fff;
		pending_mats.push_back(mt);
		mt = diag_mat(32767, -32768, -32768);
		mt.m01 = 16'sh7fff; mt.m10 = 16'sh7fff; mt.m02 = 16'sh8000; mt.m20 = 16'sh8000;
		pending_mats.push_back(mt);
		mt = diag_mat(-32768, 32767, -32768);
		mt.m12 = 16'sh7fff; mt.m21 = 16'sh7fff; mt.m20 = 16'sh8000; mt.m02 = 16'sh7fff;
		pending_mats.push_back(mt);
		mt = {9{16'sh7fff}};
		mt.m11 = 16'sh8000;
		pending_mats.push_back(mt);
		wait (arst_n);
		wait (pending_mats.size() == 0 && !in_valid && expected_quats.size() == 0);
		// drain once with the sender held
		hold_sender = 1'b1;
		repeat (LATENCY) @(posedge clk);
		hold_sender = 1'b0;
		for (int n = 0; n < N_RANDOM; n++) begin
			if ($urandom_range(0, 3) == 0) begin
				mt = mat_t'({$urandom, $urandom, $urandom, $urandom, 16'($urandom)});
			end else begin
				mt = rotation_like();
			end
			pending_mats.push_back(mt);
		end
		stimulus_done = 1'b1;
	end

	// record which transactions completed at the last rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_fire_q  <= 1'b0;
			out_fire_q <= 1'b0;
		end else begin
			in_fire_q  <= in_valid && in_ready;
			out_fire_q <= out_valid && out_ready;
		end
	end

	// driver
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data  <= '0;
			send_gap <= 0;
		end else if (in_valid && !in_fire_q) begin
			// hold the pending transaction
		end else if (send_gap > 0) begin
			in_valid <= 1'b0;
			send_gap <= send_gap - 1;
		end else if (pending_mats.size() > 0 && !hold_sender) begin
			in_valid <= 1'b1;
			in_data  <= pending_mats.pop_front();
			send_gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 3);
		end else begin
			in_valid <= 1'b0;
		end
	end

	// receiver stall
	always @(negedge clk or negedge arst_n) begin
		int wait_n;
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_gap  <= 0;
		end else if (out_fire_q) begin
			wait_n = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 3);
			out_ready <= (wait_n == 0);
			recv_gap  <= (wait_n == 0) ? 0 : wait_n - 1;
		end else if (recv_gap > 0) begin
			out_ready <= 1'b0;
			recv_gap  <= recv_gap - 1;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// monitor
	always @(posedge clk) begin
		quat_t want;
		if (arst_n) begin
			if (in_valid && in_ready)
				expected_quats.push_back(matrix_to_quat(in_data));
			if (out_valid && out_ready) begin
				if (expected_quats.size() == 0) begin
					$display("%0t: unexpected result %h", $time, out_data);
					error_count++;
				end else begin
					want = expected_quats.pop_front();
					if (out_data.qw !== want.qw)
						$display("%0t: qw expected %0d got %0d", $time, want.qw, out_data.qw);
					if (out_data.qx !== want.qx)
						$display("%0t: qx expected %0d got %0d", $time, want.qx, out_data.qx);
					if (out_data.qy !== want.qy)
						$display("%0t: qy expected %0d got %0d", $time, want.qy, out_data.qy);
					if (out_data.qz !== want.qz)
						$display("%0t: qz expected %0d got %0d", $time, want.qz, out_data.qz);
					if (out_data.invalid !== want.invalid)
						$display("%0t: invalid expected %0b got %0b", $time,
							want.invalid, out_data.invalid);
					if (out_data !== want) error_count++;
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		error_count = 0;
		idle_cycles = 0;
		stimulus_done = 1'b0;
		hold_sender = 1'b0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		fork
			begin
				wait (stimulus_done && pending_mats.size() == 0 && !in_valid
					&& expected_quats.size() == 0);
				repeat (LATENCY) @(posedge clk);
			end
			begin
				wait (idle_cycles >= WATCHDOG_LIMIT);
				error_count++;
			end
		join_any
		if (error_count == 0) $display("tb: success");
		else $display("tb: failure");
		$finish;
	end

endmodule

// File: files.f
+incdir+design
design/rmq_pkg.sv
design/rmq_front.sv
design/rmq_fifo.sv
design/rmq_back.sv
design/rotation_matrix_to_quaternion_core.sv
design/rmq_checker.sv
dv/rotation_matrix_to_quaternion_core_tb.sv
